// ----- hw/rtl/sdsc_pkg.sv -----
// Shared constants, types and state codes of the slice dropout scorer.
`timescale 1ns / 1ps
`default_nettype none

package sdsc_pkg;

    localparam int unsigned MAX_SLICES   = 128;
    localparam int unsigned B_CLASSES    = 16;
    localparam int unsigned SLICE_VOXELS = 65536;
    localparam int unsigned VOXEL_BITS   = 16;

    localparam int unsigned CLS_W     = 4;
    localparam int unsigned CNT_W     = 17;
    localparam int unsigned IDX_W     = $clog2(MAX_SLICES);
    localparam int unsigned IDX_CNT_W = $clog2(MAX_SLICES + 1);
    localparam int unsigned REF_DEPTH = B_CLASSES * MAX_SLICES;
    localparam int unsigned REF_AW    = $clog2(REF_DEPTH);

    localparam int unsigned FRM_W     = 8;
    localparam int unsigned FSUM_W    = 23;
    localparam int unsigned TOT_W     = 24;
    localparam int unsigned TSUM_W    = 40;
    localparam int unsigned AVG_W     = 16;

    localparam int unsigned DIV_Q_W   = 16;
    localparam int unsigned DIV_D_W   = 25;
    localparam int unsigned DIV_N_W   = DIV_D_W + DIV_Q_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W);

    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_FILL_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0]   FLOOR_RESET = CNT_W'(3277);
    localparam logic [TOT_W-1:0]   TOTAL_MAX   = {TOT_W{1'b1}};
    localparam logic [AVG_W-1:0]   SCORE_TWO   = AVG_W'(32768);
    localparam logic [DIV_N_W-1:0] EMPTY_NUM   = DIV_N_W'(32768);
    localparam logic [DIV_D_W-1:0] EMPTY_DEN   = DIV_D_W'(2);
    localparam logic [DIV_N_W-1:0] SCORE_SCALE = DIV_N_W'(327680);

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CLS_W-1:0] cls;
        logic [IDX_W-1:0] idx;
        logic             in_range;
        logic             run_start;
        logic             frame_end;
    } sdsc_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SDIV,
        ST_FSTART,
        ST_FDIV,
        ST_TDIV,
        ST_EMIT
    } sdsc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/slice_dropout_scorer_core.sv -----
// Top level of the slice dropout scorer: front end, slice queue and back end.
// Usage:
//   Voxels enter on the voxel channel (voxel_valid / voxel_stall) in frame, slice and
//   row order, each with its frame threshold, b-value class and slice, frame and run
//   markers. One voxel is taken per cycle while the four-entry slice queue has room.
//   Each closed slice becomes a queue transaction for the back end, which scores each
//   slice, runs a bad slice through the 16-step shared divider, and uses the divider
//   twice more at a frame end for the two averages. Slices of 19 voxels or more keep
//   the voxel stream at one voxel per cycle away from frame ends.
//   One result per frame leaves on the result channel (result_valid / result_stall)
//   after the frame's last voxel is taken, later when its last slice is bad or while
//   earlier slices are still queued; it sits in an output register, so the back end
//   carries on until the next result is due. While the receiver stalls, the back end
//   holds at that next frame end, the queue fills and voxel_stall rises. The floor
//   register is to be written on cfg_valid (cfg_ready is always high) only while
//   idle; the block itself does not enforce it. Reset clears counts, totals and class
//   references and loads the floor with 3277; the reference store is not cleared, a
//   run start must precede its use.
`timescale 1ns / 1ps
`default_nettype none

module slice_dropout_scorer_core
    import sdsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CNT_W-1:0]      cfg_data,
    input  wire logic                  voxel_valid,
    output logic                       voxel_stall,
    input  wire logic [VOXEL_BITS-1:0] voxel_value,
    input  wire logic [VOXEL_BITS-1:0] frame_threshold,
    input  wire logic [CLS_W-1:0]      b_class,
    input  wire logic                  slice_end,
    input  wire logic                  frame_end,
    input  wire logic                  run_start,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic      [FRM_W-1:0]      frame_bad_slices,
    output logic      [FRM_W-1:0]      frame_nonempty_slices,
    output logic      [AVG_W-1:0]      frame_score_avg,
    output logic      [TOT_W-1:0]      total_nonempty_slices,
    output logic      [TOT_W-1:0]      total_bad_slices,
    output logic      [AVG_W-1:0]      total_score_avg
);

    logic      rec_empty;
    logic      rec_pop;
    sdsc_rec_t rec_head;

    sdsc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .voxel_valid     (voxel_valid),
        .voxel_stall     (voxel_stall),
        .voxel_value     (voxel_value),
        .frame_threshold (frame_threshold),
        .b_class         (b_class),
        .slice_end       (slice_end),
        .frame_end       (frame_end),
        .run_start       (run_start),
        .rec_empty       (rec_empty),
        .rec_head        (rec_head),
        .rec_pop         (rec_pop)
    );

    sdsc_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_data              (cfg_data),
        .rec_empty             (rec_empty),
        .rec_head              (rec_head),
        .rec_pop               (rec_pop),
        .result_valid          (result_valid),
        .result_stall          (result_stall),
        .frame_bad_slices      (frame_bad_slices),
        .frame_nonempty_slices (frame_nonempty_slices),
        .frame_score_avg       (frame_score_avg),
        .total_nonempty_slices (total_nonempty_slices),
        .total_bad_slices      (total_bad_slices),
        .total_score_avg       (total_score_avg)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sdsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sdsc_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sdsc_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sdsc_div
    import sdsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [DIV_N_W-1:0] num,
    input  wire logic [DIV_D_W-1:0] den,
    output logic                    done,
    output logic      [DIV_Q_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    always_comb
    begin
        trial    = {rem_reg, low_reg[DIV_Q_W-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_Q_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DIV_N_W-1:DIV_Q_W];
            low_reg <= num[DIV_Q_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sdsc_front.sv -----
// Front end: per-slice voxel counting and the slice transaction queue.
`timescale 1ns / 1ps
`default_nettype none

module sdsc_front
    import sdsc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  voxel_valid,
    output logic                       voxel_stall,
    input  wire logic [VOXEL_BITS-1:0] voxel_value,
    input  wire logic [VOXEL_BITS-1:0] frame_threshold,
    input  wire logic [CLS_W-1:0]      b_class,
    input  wire logic                  slice_end,
    input  wire logic                  frame_end,
    input  wire logic                  run_start,
    output logic                       rec_empty,
    output sdsc_rec_t                  rec_head,
    input  wire logic                  rec_pop
);

    logic [CNT_W-1:0]       cnt_reg;
    logic [IDX_CNT_W-1:0]   idx_reg;
    logic                   rs_pend_reg;
    sdsc_rec_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_FILL_W-1:0] fill_reg;

    logic                   accept;
    logic                   closing;
    logic                   push;
    logic                   above;
    logic                   in_rng;
    logic [CNT_W-1:0]       base_cnt;
    logic [CNT_W-1:0]       cnt_inc;
    logic [IDX_CNT_W-1:0]   base_idx;
    sdsc_rec_t              rec_new;

    assign voxel_stall = (fill_reg == FIFO_FILL_W'(FIFO_DEPTH));
    assign accept      = voxel_valid && !voxel_stall;
    assign closing     = slice_end || frame_end;
    assign push        = accept && closing;
    assign rec_empty   = (fill_reg == '0);
    assign rec_head    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        base_cnt = run_start ? '0 : cnt_reg;
        base_idx = run_start ? '0 : idx_reg;
        above    = (voxel_value > frame_threshold) && (base_cnt < CNT_W'(SLICE_VOXELS));
        cnt_inc  = base_cnt + CNT_W'(above);
        in_rng   = base_idx < IDX_CNT_W'(MAX_SLICES);

        rec_new.count     = cnt_inc;
        rec_new.cls       = b_class;
        rec_new.idx       = base_idx[IDX_W-1:0];
        rec_new.in_range  = in_rng;
        rec_new.run_start = run_start || rs_pend_reg;
        rec_new.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            idx_reg     <= '0;
            rs_pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (closing)
            begin
                cnt_reg     <= '0;
                rs_pend_reg <= 1'b0;
                if (frame_end)
                begin
                    idx_reg <= '0;
                end
                else if (in_rng)
                begin
                    idx_reg <= base_idx + IDX_CNT_W'(1);
                end
                else
                begin
                    idx_reg <= base_idx;
                end
            end
            else
            begin
                cnt_reg     <= cnt_inc;
                idx_reg     <= base_idx;
                rs_pend_reg <= rs_pend_reg || run_start;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (rec_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            unique case ({push, rec_pop})
                2'b10:   fill_reg <= fill_reg + FIFO_FILL_W'(1);
                2'b01:   fill_reg <= fill_reg - FIFO_FILL_W'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= rec_new;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sdsc_back.sv -----
// Back end: reference store, slice scoring, frame and run totals, result register.
`timescale 1ns / 1ps
`default_nettype none

module sdsc_back
    import sdsc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CNT_W-1:0]   cfg_data,
    input  wire logic               rec_empty,
    input  wire sdsc_rec_t          rec_head,
    output logic                    rec_pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic      [FRM_W-1:0]   frame_bad_slices,
    output logic      [FRM_W-1:0]   frame_nonempty_slices,
    output logic      [AVG_W-1:0]   frame_score_avg,
    output logic      [TOT_W-1:0]   total_nonempty_slices,
    output logic      [TOT_W-1:0]   total_bad_slices,
    output logic      [AVG_W-1:0]   total_score_avg
);

    sdsc_state_t         state_reg;
    sdsc_state_t         state_next;
    sdsc_rec_t           cur_reg;
    logic [CNT_W-1:0]    floor_reg;
    logic [B_CLASSES-1:0] has_ref_reg;
    logic [B_CLASSES-1:0] storing_reg;
    logic [FRM_W-1:0]    frame_bad_reg;
    logic [FRM_W-1:0]    frame_ne_reg;
    logic [FSUM_W-1:0]   frame_sum_reg;
    logic [TOT_W-1:0]    total_ne_reg;
    logic [TOT_W-1:0]    total_bad_reg;
    logic [TSUM_W-1:0]   total_sum_reg;
    logic [AVG_W-1:0]    favg_reg;
    logic [AVG_W-1:0]    tavg_reg;
    logic                out_valid_reg;
    logic [FRM_W-1:0]    out_fbad_reg;
    logic [FRM_W-1:0]    out_fne_reg;
    logic [AVG_W-1:0]    out_favg_reg;
    logic [TOT_W-1:0]    out_tne_reg;
    logic [TOT_W-1:0]    out_tbad_reg;
    logic [AVG_W-1:0]    out_tavg_reg;

    logic [CNT_W-1:0]    ref_rdata;
    logic [CNT_W-1:0]    ref_val;
    logic [REF_AW-1:0]   ref_raddr;
    logic [REF_AW-1:0]   ref_waddr;
    logic                ref_we;
    logic                act;
    logic                cls_ok;
    logic                storing;
    logic                nonempty;
    logic                bad;
    logic [CNT_W+3:0]    count_x10;
    logic [CNT_W+3:0]    ref_x7;
    logic                slot_free;
    logic                out_load;
    logic                div_start;
    logic [DIV_N_W-1:0]  div_num;
    logic [DIV_D_W-1:0]  div_den;
    logic                div_done;
    logic [DIV_Q_W-1:0]  div_q;
    logic [AVG_W-1:0]    score;

    sdsc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (REF_DEPTH)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (cur_reg.count),
        .raddr (ref_raddr),
        .rdata (ref_rdata)
    );

    sdsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign cfg_ready = 1'b1;
    assign ref_raddr = {rec_head.cls, rec_head.idx};
    assign ref_waddr = {cur_reg.cls, cur_reg.idx};
    assign slot_free = !out_valid_reg || !result_stall;
    assign score     = SCORE_TWO - div_q;

    always_comb
    begin
        cls_ok    = {1'b0, cur_reg.cls} < (CLS_W + 1)'(B_CLASSES);
        act       = cur_reg.in_range && cls_ok;
        storing   = !has_ref_reg[cur_reg.cls] || storing_reg[cur_reg.cls];
        ref_val   = storing ? cur_reg.count : ref_rdata;
        count_x10 = {3'b0, cur_reg.count, 1'b0} + {1'b0, cur_reg.count, 3'b0};
        ref_x7    = {1'b0, ref_val, 3'b0} - {4'b0, ref_val};
        nonempty  = act && (cur_reg.count >= floor_reg);
        bad       = nonempty && (ref_val != '0) && (count_x10 < ref_x7);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!rec_empty)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (bad)
                begin
                    state_next = ST_SDIV;
                end
                else if (cur_reg.frame_end)
                begin
                    state_next = ST_FSTART;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SDIV:
            begin
                if (div_done)
                begin
                    state_next = cur_reg.frame_end ? ST_FSTART : ST_IDLE;
                end
            end
            ST_FSTART:
            begin
                state_next = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rec_pop   = 1'b0;
        ref_we    = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        div_num   = EMPTY_NUM;
        div_den   = EMPTY_DEN;
        unique case (state_reg)
            ST_IDLE:
            begin
                rec_pop = !rec_empty;
            end
            ST_LOOK:
            begin
                ref_we    = act && storing;
                div_start = bad;
                div_num   = DIV_N_W'({3'b0, cur_reg.count} * 20'd5) * DIV_N_W'(65536)
                            + DIV_N_W'(ref_x7);
                div_den   = DIV_D_W'({ref_x7, 1'b0});
            end
            ST_FSTART:
            begin
                div_start = 1'b1;
                if (frame_bad_reg != '0)
                begin
                    div_num = DIV_N_W'({frame_sum_reg, 1'b0}) + DIV_N_W'(frame_bad_reg);
                    div_den = DIV_D_W'({frame_bad_reg, 1'b0});
                end
            end
            ST_FDIV:
            begin
                div_start = div_done;
                if (total_bad_reg != '0)
                begin
                    div_num = DIV_N_W'({total_sum_reg, 1'b0}) + DIV_N_W'(total_bad_reg);
                    div_den = DIV_D_W'({total_bad_reg, 1'b0});
                end
            end
            ST_EMIT:
            begin
                out_load = slot_free;
            end
            default:
            begin
                rec_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            floor_reg     <= FLOOR_RESET;
            has_ref_reg   <= '0;
            storing_reg   <= '0;
            frame_bad_reg <= '0;
            frame_ne_reg  <= '0;
            frame_sum_reg <= '0;
            total_ne_reg  <= '0;
            total_bad_reg <= '0;
            total_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                floor_reg <= cfg_data;
            end
            if (rec_pop && rec_head.run_start)
            begin
                has_ref_reg   <= '0;
                storing_reg   <= '0;
                frame_bad_reg <= '0;
                frame_ne_reg  <= '0;
                frame_sum_reg <= '0;
            end
            if ((state_reg == ST_LOOK) && act)
            begin
                if (!has_ref_reg[cur_reg.cls])
                begin
                    has_ref_reg[cur_reg.cls] <= 1'b1;
                    storing_reg[cur_reg.cls] <= 1'b1;
                end
                if (nonempty)
                begin
                    frame_ne_reg <= frame_ne_reg + FRM_W'(1);
                    if (total_ne_reg != TOTAL_MAX)
                    begin
                        total_ne_reg <= total_ne_reg + TOT_W'(1);
                    end
                end
            end
            if ((state_reg == ST_SDIV) && div_done)
            begin
                frame_bad_reg <= frame_bad_reg + FRM_W'(1);
                frame_sum_reg <= frame_sum_reg + FSUM_W'(score);
                if (total_bad_reg != TOTAL_MAX)
                begin
                    total_bad_reg <= total_bad_reg + TOT_W'(1);
                    total_sum_reg <= total_sum_reg + TSUM_W'(score);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                storing_reg   <= '0;
                frame_bad_reg <= '0;
                frame_ne_reg  <= '0;
                frame_sum_reg <= '0;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            cur_reg <= rec_head;
        end
        if ((state_reg == ST_FDIV) && div_done)
        begin
            favg_reg <= div_q;
        end
        if ((state_reg == ST_TDIV) && div_done)
        begin
            tavg_reg <= div_q;
        end
        if (out_load)
        begin
            out_fbad_reg <= frame_bad_reg;
            out_fne_reg  <= frame_ne_reg;
            out_favg_reg <= favg_reg;
            out_tne_reg  <= total_ne_reg;
            out_tbad_reg <= total_bad_reg;
            out_tavg_reg <= tavg_reg;
        end
    end

    assign result_valid          = out_valid_reg;
    assign frame_bad_slices      = out_fbad_reg;
    assign frame_nonempty_slices = out_fne_reg;
    assign frame_score_avg       = out_favg_reg;
    assign total_nonempty_slices = out_tne_reg;
    assign total_bad_slices      = out_tbad_reg;
    assign total_score_avg       = out_tavg_reg;

endmodule

`default_nettype wire

// ----- tb/slice_dropout_scorer_core_tb.sv -----
// Self-checking testbench of the slice dropout scorer: voxel streams in, frame results checked.
`timescale 1ns / 1ps

module slice_dropout_scorer_core_tb;
    import sdsc_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned FLOOR_TOP     = 65536;
    localparam int unsigned ONE_Q14       = 16384;

    typedef struct packed {
        logic [VOXEL_BITS-1:0] value;
        logic [VOXEL_BITS-1:0] threshold;
        logic [CLS_W-1:0]      cls;
        logic                  s_end;
        logic                  f_end;
        logic                  r_start;
    } voxel_t;

    typedef struct packed {
        logic [FRM_W-1:0] bad;
        logic [FRM_W-1:0] nonempty;
        logic [AVG_W-1:0] score_avg;
        logic [TOT_W-1:0] tot_nonempty;
        logic [TOT_W-1:0] tot_bad;
        logic [AVG_W-1:0] tot_score_avg;
    } frame_result_t;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data        = '0;
    logic                  voxel_valid     = 1'b0;
    logic                  voxel_stall;
    logic [VOXEL_BITS-1:0] voxel_value     = '0;
    logic [VOXEL_BITS-1:0] frame_threshold = '0;
    logic [CLS_W-1:0]      b_class         = '0;
    logic                  slice_end       = 1'b0;
    logic                  frame_end       = 1'b0;
    logic                  run_start       = 1'b0;
    logic                  result_valid;
    logic                  result_stall    = 1'b0;
    logic [FRM_W-1:0]      frame_bad_slices;
    logic [FRM_W-1:0]      frame_nonempty_slices;
    logic [AVG_W-1:0]      frame_score_avg;
    logic [TOT_W-1:0]      total_nonempty_slices;
    logic [TOT_W-1:0]      total_bad_slices;
    logic [AVG_W-1:0]      total_score_avg;

    slice_dropout_scorer_core DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    voxel_t        pending_voxels[$];
    frame_result_t frame_results_due[$];
    int unsigned   tx_idle_pct   = 26;
    int unsigned   rx_idle_pct   = 63;
    logic          rx_hold       = 1'b0;
    bit            hold_wanted   = 1'b0;
    logic          vox_fire      = 1'b0;
    int unsigned   mismatches    = 0;
    int unsigned   queued_n      = 0;
    int unsigned   frames_queued = 0;

    // scoring state
    logic [CNT_W-1:0]     floor_q = FLOOR_RESET;
    int unsigned          open_count;
    int unsigned          slice_pos;
    int unsigned          ref_store[REF_DEPTH];
    logic [B_CLASSES-1:0] ref_valid   = '0;
    logic [B_CLASSES-1:0] ref_loading = '0;
    int unsigned          frm_bad;
    int unsigned          frm_nonempty;
    int unsigned          frm_score_sum;
    int unsigned          tot_nonempty;
    int unsigned          tot_bad;
    longint unsigned      tot_score_sum;

    // stimulus-side tracking of which reference entries hold data
    logic [B_CLASSES-1:0] g_has_ref  = '0;
    logic [B_CLASSES-1:0] g_loading  = '0;
    int unsigned          g_pos      = 0;
    bit                   g_written[REF_DEPTH];

    function automatic longint unsigned q14_mean(longint unsigned sum, longint unsigned n);
        if (n == 0)
            return ONE_Q14;
        return (2 * sum + n) / (2 * n);
    endfunction

    function automatic void clear_frame_state();
        open_count    = 0;
        slice_pos     = 0;
        ref_loading   = '0;
        frm_bad       = 0;
        frm_nonempty  = 0;
        frm_score_sum = 0;
    endfunction

    function automatic bit score_voxel(input voxel_t v, output frame_result_t r);
        int unsigned     cnt;
        int unsigned     pos;
        int unsigned     refc;
        int unsigned     score;
        longint unsigned q;
        r = '0;
        if (v.r_start)
        begin
            ref_valid = '0;
            clear_frame_state();
        end
        if (v.value > v.threshold && open_count < SLICE_VOXELS)
            open_count++;
        if (v.s_end || v.f_end)
        begin
            cnt        = open_count;
            open_count = 0;
            if (slice_pos < MAX_SLICES)
            begin
                if (v.cls < B_CLASSES)
                begin
                    pos = v.cls * MAX_SLICES + slice_pos;
                    if (!ref_valid[v.cls])
                    begin
                        ref_valid[v.cls]   = 1'b1;
                        ref_loading[v.cls] = 1'b1;
                    end
                    if (ref_loading[v.cls])
                        ref_store[pos] = cnt;
                    refc = ref_store[pos];
                    if (cnt >= floor_q)
                    begin
                        frm_nonempty++;
                        if (tot_nonempty < TOTAL_MAX)
                            tot_nonempty++;
                        if (refc != 0 && 10 * longint'(cnt) < 7 * longint'(refc))
                        begin
                            q = (327680 * longint'(cnt) + 7 * longint'(refc))
                                / (14 * longint'(refc));
                            score = 32768 - int'(q);
                            frm_bad++;
                            frm_score_sum += score;
                            if (tot_bad < TOTAL_MAX)
                            begin
                                tot_bad++;
                                tot_score_sum += score;
                            end
                        end
                    end
                end
                slice_pos++;
            end
        end
        if (!v.f_end)
            return 1'b0;
        r.bad           = (frm_bad > 255) ? FRM_W'(255) : FRM_W'(frm_bad);
        r.nonempty      = (frm_nonempty > 255) ? FRM_W'(255) : FRM_W'(frm_nonempty);
        r.score_avg     = AVG_W'(q14_mean(frm_score_sum, frm_bad));
        r.tot_nonempty  = TOT_W'(tot_nonempty);
        r.tot_bad       = TOT_W'(tot_bad);
        r.tot_score_avg = AVG_W'(q14_mean(tot_score_sum, tot_bad));
        clear_frame_state();
        return 1'b1;
    endfunction

    function automatic voxel_t mk_voxel(int unsigned value, int unsigned thr,
                                        int unsigned cls, bit se, bit fe, bit rs);
        voxel_t v;
        v.value     = VOXEL_BITS'(value);
        v.threshold = VOXEL_BITS'(thr);
        v.cls       = CLS_W'(cls);
        v.s_end     = se;
        v.f_end     = fe;
        v.r_start   = rs;
        return v;
    endfunction

    // a slice that would read a reference entry never written gets a run start instead
    task automatic queue_voxel(input voxel_t v);
        int unsigned pos;
        pos = v.cls * MAX_SLICES + g_pos;
        if (!v.r_start && (v.s_end || v.f_end) && g_pos < MAX_SLICES && g_has_ref[v.cls]
            && !g_loading[v.cls] && !g_written[pos])
            v.r_start = 1'b1;
        if (v.r_start)
        begin
            g_has_ref = '0;
            g_loading = '0;
            g_pos     = 0;
        end
        if ((v.s_end || v.f_end) && g_pos < MAX_SLICES)
        begin
            pos = v.cls * MAX_SLICES + g_pos;
            if (!g_has_ref[v.cls])
            begin
                g_has_ref[v.cls] = 1'b1;
                g_loading[v.cls] = 1'b1;
            end
            if (g_loading[v.cls])
                g_written[pos] = 1'b1;
            g_pos++;
        end
        if (v.f_end)
        begin
            g_pos     = 0;
            g_loading = '0;
            frames_queued++;
        end
        pending_voxels = {pending_voxels, v};
        queued_n++;
    endtask

    task automatic gen_run();
        int unsigned      n_slices;
        int unsigned      n_frames;
        int unsigned      lens[5];
        int unsigned      level;
        int unsigned      thr;
        logic [CLS_W-1:0] classes[2];
        voxel_t           v;
        bit               first;
        bit               last_vox;
        n_slices   = $urandom_range(1, 5);
        n_frames   = $urandom_range(2, 4);
        classes[0] = CLS_W'($urandom_range(0, B_CLASSES - 1));
        classes[1] = CLS_W'($urandom_range(0, B_CLASSES - 1));
        foreach (lens[i])
            lens[i] = $urandom_range(1, 10);
        first = 1'b1;
        for (int f = 0; f < n_frames; f++)
        begin
            case ($urandom_range(0, 9))
                0:       thr = 0;
                1:       thr = 65535;
                default: thr = $urandom_range(0, 65535);
            endcase
            v.cls = classes[$urandom_range(0, 1)];
            for (int s = 0; s < n_slices; s++)
            begin
                level = $urandom_range(0, 4) * 25;
                for (int k = 0; k < lens[s]; k++)
                begin
                    last_vox    = (k == lens[s] - 1);
                    v.threshold = VOXEL_BITS'(thr);
                    if ($urandom_range(0, 99) < level && thr < 65535)
                        v.value = VOXEL_BITS'($urandom_range(thr + 1, 65535));
                    else
                        v.value = VOXEL_BITS'($urandom_range(0, thr));
                    v.f_end   = last_vox && (s == n_slices - 1);
                    v.s_end   = last_vox && (!v.f_end || $urandom_range(0, 3) != 0);
                    v.r_start = first;
                    first     = 1'b0;
                    queue_voxel(v);
                    if (!last_vox && $urandom_range(0, 7) == 0)
                        v.cls = CLS_W'($urandom_range(0, B_CLASSES - 1));
                    else if (last_vox)
                        v.cls = classes[$urandom_range(0, 1)];
                end
            end
        end
    endtask

    task automatic gen_noise(int unsigned n);
        for (int i = 0; i < n; i++)
            queue_voxel(mk_voxel($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, B_CLASSES - 1), $urandom_range(0, 1),
                                 $urandom_range(0, 5) == 0, $urandom_range(0, 15) == 0));
    endtask

    task automatic random_part(int unsigned n_items, int unsigned n_frames);
        int unsigned item_goal;
        int unsigned frame_goal;
        item_goal  = queued_n + n_items;
        frame_goal = frames_queued + n_frames;
        while (queued_n < item_goal || frames_queued < frame_goal)
        begin
            if ($urandom_range(0, 9) < 8)
                gen_run();
            else
                gen_noise($urandom_range(1, 6));
        end
    endtask

    task automatic wait_quiet();
        while (pending_voxels.size() != 0 || voxel_valid || frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_floor(int unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin : sender
        voxel_t cur;
        if (!rst_n)
            voxel_valid <= 1'b0;
        else if (voxel_valid && !vox_fire)
        begin
            // hold the stalled transaction
        end
        else if (pending_voxels.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
        begin
            cur = pending_voxels.pop_front();
            voxel_value     <= cur.value;
            frame_threshold <= cur.threshold;
            b_class         <= cur.cls;
            slice_end       <= cur.s_end;
            frame_end       <= cur.f_end;
            run_start       <= cur.r_start;
            voxel_valid     <= 1'b1;
        end
        else
            voxel_valid <= 1'b0;
    end

    always @(negedge clk)
        result_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);

    initial
    begin : hold_off
        wait (hold_wanted);
        @(negedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        @(negedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : monitor
        frame_result_t got;
        frame_result_t want;
        voxel_t        seen;
        if (!rst_n)
            vox_fire <= 1'b0;
        else
        begin
            vox_fire <= voxel_valid && !voxel_stall;
            if (cfg_valid && cfg_ready)
                floor_q = cfg_data;
            if (result_valid && !result_stall)
            begin
                got = {frame_bad_slices, frame_nonempty_slices, frame_score_avg,
                       total_nonempty_slices, total_bad_slices, total_score_avg};
                if (frame_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: frame result with none due: %0d %0d %0d %0d %0d %0d",
                                 $realtime, got.bad, got.nonempty, got.score_avg,
                                 got.tot_nonempty, got.tot_bad, got.tot_score_avg);
                end
                else
                begin
                    want = frame_results_due.pop_front();
                    if (got.bad != want.bad || got.nonempty != want.nonempty
                        || got.score_avg != want.score_avg
                        || got.tot_nonempty != want.tot_nonempty
                        || got.tot_bad != want.tot_bad
                        || got.tot_score_avg != want.tot_score_avg)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $write("%0t: frame result differs: expected %0d %0d %0d %0d %0d %0d,",
                                   $realtime,
                                   want.bad, want.nonempty, want.score_avg,
                                   want.tot_nonempty, want.tot_bad, want.tot_score_avg);
                            $display(" actual %0d %0d %0d %0d %0d %0d",
                                     got.bad, got.nonempty, got.score_avg,
                                     got.tot_nonempty, got.tot_bad, got.tot_score_avg);
                        end
                    end
                end
            end
            if (voxel_valid && !voxel_stall)
            begin
                seen = {voxel_value, frame_threshold, b_class, slice_end, frame_end, run_start};
                if (score_voxel(seen, want))
                    frame_results_due = {frame_results_due, want};
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycle_n;
        cycle_n = 0;
        while (cycle_n < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_n++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset floor, sender idles lightly, receiver heavily
        random_part(20, 2);
        wait_quiet();

        write_floor(0);
        // reference frame: full slice, zero-count slice, class taken from the last voxel,
        // frame end closing the slice
        queue_voxel(mk_voxel(65535, 0, 1, 0, 0, 1));
        queue_voxel(mk_voxel(65535, 0, 1, 0, 0, 0));
        queue_voxel(mk_voxel(65535, 0, 1, 0, 0, 0));
        queue_voxel(mk_voxel(65535, 0, 1, 1, 0, 0));
        queue_voxel(mk_voxel(0, 65535, 1, 0, 0, 0));
        queue_voxel(mk_voxel(0, 65535, 1, 1, 0, 0));
        queue_voxel(mk_voxel(100, 99, 7, 0, 0, 0));
        queue_voxel(mk_voxel(100, 99, 7, 0, 0, 0));
        queue_voxel(mk_voxel(100, 99, 1, 0, 1, 0));
        // scored frame: dropout slice, zero reference, empty slice at top score
        queue_voxel(mk_voxel(200, 100, 1, 0, 0, 0));
        queue_voxel(mk_voxel(0, 100, 1, 1, 0, 0));
        queue_voxel(mk_voxel(5, 4, 1, 0, 0, 0));
        queue_voxel(mk_voxel(5, 4, 1, 1, 0, 0));
        queue_voxel(mk_voxel(3, 3, 1, 1, 1, 0));
        // run start in the middle of a frame drops the slice closed before it from the frame counts
        queue_voxel(mk_voxel(65535, 0, 2, 0, 0, 0));
        queue_voxel(mk_voxel(65535, 0, 2, 1, 0, 0));
        queue_voxel(mk_voxel(1, 0, 2, 0, 0, 1));
        queue_voxel(mk_voxel(1, 0, 2, 1, 1, 0));
        queue_voxel(mk_voxel(0, 0, 15, 1, 1, 0));
        queue_voxel(mk_voxel(65535, 65534, 8, 0, 1, 0));
        wait_quiet();

        write_floor(2);
        random_part(30, 3);
        hold_wanted = 1'b1;
        wait_quiet();
        random_part(20, 2);
        wait_quiet();

        tx_idle_pct = 63;
        rx_idle_pct = 26;
        write_floor(1);
        random_part(30, 3);
        wait_quiet();
        write_floor(5);
        random_part(20, 2);
        wait_quiet();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_floor(0);
        // frame longer than the slice store
        for (int i = 0; i < MAX_SLICES + 2; i++)
            queue_voxel(mk_voxel(i % 2, 0, 9, 1, i == MAX_SLICES + 1, i == 0));
        random_part(20, 2);
        wait_quiet();

        write_floor(FLOOR_TOP);
        random_part(10, 1);
        wait_quiet();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sdsc_pkg.sv
hw/rtl/sdsc_ram.sv
hw/rtl/sdsc_div.sv
hw/rtl/sdsc_front.sv
hw/rtl/sdsc_back.sv
hw/rtl/slice_dropout_scorer_core.sv
tb/slice_dropout_scorer_core_tb.sv
